>>> rtl/core/adp_pkg.sv
package adp_pkg;

  localparam int STEP_W = 21;
  localparam int MEM_W  = 96;

  localparam logic [31:0] BETA_ONE_RST  = 32'd3865470566;
  localparam logic [31:0] BETA_TWO_RST  = 32'd4290672329;
  localparam logic [31:0] LR_RST        = 32'd4294967;
  localparam logic [STEP_W-1:0] STEP_RST = 21'd1;
  localparam logic [31:0] BIAS_ONE_RST  = 32'd429496730;
  localparam logic [31:0] BIAS_TWO_RST  = 32'd4294967;
  localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
  localparam logic [63:0] EPS_Q32       = 64'd43;
  localparam logic [40:0] UPDATE_CAP    = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    REG_BETA_ONE    = 2'd0,
    REG_BETA_TWO    = 2'd1,
    REG_STEP_SIZE   = 2'd2,
    REG_STEP_NUMBER = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] beta_one;
    logic [31:0] beta_two;
    logic [31:0] step_size;
    logic [31:0] bias_one;
    logic [31:0] bias_two;
    logic        busy;
  } adp_cfg_t;

  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] gradient;
    logic        last;
  } adp_item_t;

endpackage

>>> rtl/core/adp_cfg.sv
module adp_cfg import adp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output adp_cfg_t    regs
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOAD = 3'b010,
    B_RUN  = 3'b100
  } bias_state_t;

  bias_state_t       state;
  logic [31:0]       beta_one, beta_two, step_size, bias_one, bias_two;
  logic [STEP_W-1:0] step_number, tsh;
  logic              sel;
  logic [4:0]        cnt;
  logic [32:0]       acc, acc_next;
  logic [31:0]       base;
  logic [64:0]       acc_mul;
  logic [63:0]       base_sq;
  logic [32:0]       diff;
  logic [31:0]       bias_val;
  logic              wr;

  assign cfg_ready = (state == B_IDLE);
  assign wr        = cfg_valid && cfg_ready;

  assign acc_mul  = acc * {1'b0, base};
  assign base_sq  = base * base;
  assign acc_next = tsh[0] ? acc_mul[64:32] : acc;
  assign diff     = ONE_Q32 - acc_next;

  always_comb begin
    if (acc_next == '0) begin
      bias_val = 32'hFFFF_FFFF;
    end else if (diff == '0) begin
      bias_val = 32'd1;
    end else begin
      bias_val = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      beta_one    <= BETA_ONE_RST;
      beta_two    <= BETA_TWO_RST;
      step_size   <= LR_RST;
      step_number <= STEP_RST;
      bias_one    <= BIAS_ONE_RST;
      bias_two    <= BIAS_TWO_RST;
      sel         <= 1'b0;
      cnt         <= '0;
      acc         <= '0;
      base        <= '0;
      tsh         <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (wr) begin
            sel <= 1'b0;
            case (cfg_reg_t'(cfg_index))
              REG_BETA_ONE: begin
                beta_one <= cfg_data;
                state    <= B_LOAD;
              end
              REG_BETA_TWO: begin
                beta_two <= cfg_data;
                state    <= B_LOAD;
              end
              REG_STEP_SIZE: step_size <= cfg_data;
              REG_STEP_NUMBER: begin
                step_number <= cfg_data[STEP_W-1:0];
                state       <= B_LOAD;
              end
              default: ;
            endcase
          end
        end
        B_LOAD: begin
          acc   <= ONE_Q32;
          base  <= sel ? beta_two : beta_one;
          tsh   <= step_number;
          cnt   <= '0;
          state <= B_RUN;
        end
        B_RUN: begin
          acc  <= acc_next;
          base <= base_sq[63:32];
          tsh  <= tsh >> 1;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(STEP_W - 1)) begin
            if (!sel) begin
              bias_one <= bias_val;
              sel      <= 1'b1;
              state    <= B_LOAD;
            end else begin
              bias_two <= bias_val;
              state    <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_comb begin
    regs.beta_one  = beta_one;
    regs.beta_two  = beta_two;
    regs.step_size = step_size;
    regs.bias_one  = bias_one;
    regs.bias_two  = bias_two;
    regs.busy      = (state != B_IDLE);
  end

`ifndef SYNTHESIS
  a_bias_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> (bias_one != '0 && bias_two != '0))
    else $error("bias term zero");
`endif

endmodule

>>> rtl/core/adp_front.sv
module adp_front import adp_pkg::*; #(
  parameter int LAYERS   = 8,
  parameter int ELEMENTS = 1024,
  localparam int DEPTH   = LAYERS * ELEMENTS,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clearing,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [79:0]   s_axis_tdata,
  input  logic          s_axis_tlast,
  output logic          head_valid,
  output adp_item_t     head_item,
  output logic [AW-1:0] head_addr,
  input  logic          pop
);

  localparam int LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  logic [26:0]    lrem, erem1, erem2;
  logic           s1_valid;
  logic [LW-1:0]  s1_layer;
  logic [9:0]     s1_elem;
  adp_item_t      s1_item;
  logic [AW-1:0]  addr;
  adp_item_t      q_item [QD];
  logic [AW-1:0]  q_addr [QD];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           accept, push;

  assign s_axis_tready = !clearing && ((4'(count) + 4'(s1_valid)) < 4'(QD));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = s1_valid;

  always_comb begin
    lrem  = {24'b0, s_axis_tdata[2:0]};
    erem1 = {17'b0, s_axis_tdata[12:3]};
    for (int k = 2; k >= 0; k--) begin
      if (lrem >= (27'(LAYERS) << k)) lrem = lrem - (27'(LAYERS) << k);
    end
    for (int k = 9; k >= 5; k--) begin
      if (erem1 >= (27'(ELEMENTS) << k)) erem1 = erem1 - (27'(ELEMENTS) << k);
    end
  end

  always_comb begin
    erem2 = {17'b0, s1_elem};
    for (int k = 4; k >= 0; k--) begin
      if (erem2 >= (27'(ELEMENTS) << k)) erem2 = erem2 - (27'(ELEMENTS) << k);
    end
    addr = AW'(s1_layer) * AW'(ELEMENTS) + AW'(erem2);
  end

  always_ff @(posedge clk) begin
    s1_layer         <= lrem[LW-1:0];
    s1_elem          <= erem1[9:0];
    s1_item.weight   <= s_axis_tdata[44:13];
    s1_item.gradient <= s_axis_tdata[76:45];
    s1_item.last     <= s_axis_tlast;
    if (push) begin
      q_item[wr_ptr] <= s1_item;
      q_addr[wr_ptr] <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      s1_valid <= accept;
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign head_valid = (count != '0);
  assign head_item  = q_item[rd_ptr];
  assign head_addr  = q_addr[rd_ptr];

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < (QAW+1)'(QD)))
    else $error("queue overflow");
`endif

endmodule

>>> rtl/core/adp_exec.sv
module adp_exec import adp_pkg::*; #(
  parameter int LAYERS   = 8,
  parameter int ELEMENTS = 1024,
  localparam int DEPTH   = LAYERS * ELEMENTS,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  adp_cfg_t      regs,
  input  logic          head_valid,
  input  adp_item_t     head_item,
  input  logic [AW-1:0] head_addr,
  output logic          pop,
  output logic          clearing,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  typedef enum logic [20:0] {
    S_CLR  = 21'h000001,
    S_IDLE = 21'h000002,
    S_RD   = 21'h000004,
    S_M1A  = 21'h000008,
    S_M1B  = 21'h000010,
    S_G2   = 21'h000020,
    S_V1   = 21'h000040,
    S_V2   = 21'h000080,
    S_V3   = 21'h000100,
    S_V4   = 21'h000200,
    S_V5   = 21'h000400,
    S_DM   = 21'h000800,
    S_VS   = 21'h001000,
    S_DV   = 21'h002000,
    S_SQ   = 21'h004000,
    S_L1   = 21'h008000,
    S_L2   = 21'h010000,
    S_L3   = 21'h020000,
    S_UC   = 21'h040000,
    S_DU   = 21'h080000,
    S_FIN  = 21'h100000
  } exec_state_t;

  exec_state_t        state;
  logic [AW-1:0]      clr_cnt, addr_r, mem_wa;
  logic [MEM_W-1:0]   mem [DEPTH];
  logic [MEM_W-1:0]   mem_q, mem_wd;
  logic               mem_we;
  logic [31:0]        w_r, g_r, g_mag, m1, m1_mag, s;
  logic               last_r, neg;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [63:0]        acc, g2, sum_m, v2_sum, mhat, vhat_n;
  logic [95:0]        num;
  logic [47:0]        d_u;
  logic [40:0]        upd;
  logic [32:0]        one_b1, one_b2;
  logic [47:0]        rem, dvs, rem_n;
  logic [63:0]        dsr, quo, quo_n;
  logic [48:0]        dtrial;
  logic               dge;
  logic [6:0]         dcnt;
  logic [63:0]        sx, sres, sbit, strial, sx_n, sres_n;
  logic               sge;
  logic [4:0]         scnt;
  logic [42:0]        res;
  logic               sat;
  logic               out_load;

  assign clearing = (state == S_CLR);
  assign pop      = (state == S_IDLE) && head_valid && !regs.busy;
  assign one_b1   = ONE_Q32 - {1'b0, regs.beta_one};
  assign one_b2   = ONE_Q32 - {1'b0, regs.beta_two};
  assign g_mag    = g_r[31] ? (~g_r + 32'd1) : g_r;
  assign m1_mag   = m1[31] ? (~m1 + 32'd1) : m1;
  assign sum_m    = acc + prod[63:0];
  assign v2_sum   = acc + {32'b0, prod[63:32]};
  assign d_u      = {s, 16'b0};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_M1A: begin
        ma = {2'b0, regs.beta_one};
        mb = {{2{mem_q[31]}}, mem_q[31:0]};
      end
      S_M1B: begin
        ma = {1'b0, one_b1};
        mb = {{2{g_r[31]}}, g_r};
      end
      S_G2: begin
        ma = {2'b0, g_mag};
        mb = {2'b0, g_mag};
      end
      S_V1: begin
        ma = {2'b0, mem_q[95:64]};
        mb = {2'b0, regs.beta_two};
      end
      S_V2: begin
        ma = {2'b0, mem_q[63:32]};
        mb = {2'b0, regs.beta_two};
      end
      S_V3: begin
        ma = {2'b0, g2[63:32]};
        mb = {1'b0, one_b2};
      end
      S_V4: begin
        ma = {2'b0, g2[31:0]};
        mb = {1'b0, one_b2};
      end
      S_L1: begin
        ma = {2'b0, regs.step_size};
        mb = {2'b0, mhat[63:32]};
      end
      S_L2: begin
        ma = {2'b0, regs.step_size};
        mb = {2'b0, mhat[31:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    dtrial = {rem, dsr[63]};
    dge    = (dtrial >= {1'b0, dvs});
    rem_n  = dge ? 48'(dtrial - {1'b0, dvs}) : dtrial[47:0];
    quo_n  = {quo[62:0], dge};
  end

  always_comb begin
    sbit   = 64'd1 << {scnt, 1'b0};
    strial = sres + sbit;
    sge    = (sx >= strial);
    sx_n   = sge ? (sx - strial) : sx;
    sres_n = sge ? ((sres >> 1) + sbit) : (sres >> 1);
  end

  assign vhat_n = quo_n;

  always_comb begin
    res = neg ? ({{11{w_r[31]}}, w_r} + {2'b0, upd})
              : ({{11{w_r[31]}}, w_r} - {2'b0, upd});
    sat = (res[42:31] != {12{res[42]}});
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = {v2_sum, m1};
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
      end
      S_V5: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[addr_r];
  end

  assign out_load = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (pop) state <= S_RD;
        S_RD:   state <= S_M1A;
        S_M1A:  state <= S_M1B;
        S_M1B:  state <= S_G2;
        S_G2:   state <= S_V1;
        S_V1:   state <= S_V2;
        S_V2:   state <= S_V3;
        S_V3:   state <= S_V4;
        S_V4:   state <= S_V5;
        S_V5:   state <= S_DM;
        S_DM:   if (dcnt == 7'd1) state <= S_VS;
        S_VS:   state <= (acc[63:32] >= regs.bias_two) ? S_SQ : S_DV;
        S_DV:   if (dcnt == 7'd1) state <= S_SQ;
        S_SQ:   if (scnt == '0) state <= S_L1;
        S_L1:   state <= S_L2;
        S_L2:   state <= S_L3;
        S_L3:   state <= S_UC;
        S_UC:   state <= (num[95:40] >= {8'b0, d_u}) ? S_FIN : S_DU;
        S_DU:   if (dcnt == 7'd1) state <= S_FIN;
        S_FIN:  if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (state)
      S_IDLE: begin
        addr_r <= head_addr;
        w_r    <= head_item.weight;
        g_r    <= head_item.gradient;
        last_r <= head_item.last;
      end
      S_M1B: acc <= prod[63:0];
      S_G2:  m1  <= sum_m[63:32];
      S_V1:  g2  <= prod[63:0];
      S_V2:  acc <= prod[63:0];
      S_V3:  acc <= acc + {32'b0, prod[63:32]};
      S_V4:  acc <= acc + prod[63:0];
      S_V5: begin
        acc  <= v2_sum;
        neg  <= m1[31];
        rem  <= '0;
        dsr  <= {m1_mag, 32'b0};
        dvs  <= {16'b0, regs.bias_one};
        quo  <= '0;
        dcnt <= 7'd64;
      end
      S_DM, S_DV, S_DU: begin
        rem  <= rem_n;
        dsr  <= dsr << 1;
        quo  <= quo_n;
        dcnt <= dcnt - 7'd1;
        if (dcnt == 7'd1) begin
          if (state == S_DM) mhat <= quo_n;
          if (state == S_DU) upd <= quo_n[40:0];
          if (state == S_DV) begin
            sx   <= (vhat_n > ~EPS_Q32) ? '1 : (vhat_n + EPS_Q32);
            sres <= '0;
            scnt <= 5'd31;
          end
        end
      end
      S_VS: begin
        sres <= '0;
        scnt <= 5'd31;
        sx   <= '1;
        rem  <= {16'b0, acc[63:32]};
        dsr  <= {acc[31:0], 32'b0};
        dvs  <= {16'b0, regs.bias_two};
        quo  <= '0;
        dcnt <= 7'd64;
      end
      S_SQ: begin
        sx   <= sx_n;
        sres <= sres_n;
        scnt <= scnt - 5'd1;
        if (scnt == '0) s <= sres_n[31:0];
      end
      S_L2: acc <= prod[63:0];
      S_L3: num <= {acc, 32'b0} + {32'b0, prod[63:0]};
      S_UC: begin
        upd  <= UPDATE_CAP;
        rem  <= num[87:40];
        dsr  <= {num[39:0], 24'b0};
        dvs  <= d_u;
        quo  <= '0;
        dcnt <= 7'd40;
      end
      S_FIN: begin
        if (out_load) begin
          m_axis_tdata <= sat ? (res[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res[31:0];
          m_axis_tuser <= sat;
          m_axis_tlast <= last_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DM || state == S_DV || state == S_DU) |-> (rem < dvs))
    else $error("divider remainder not below divisor");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_FIN))
    else $error("result beat not from final step");
`endif

endmodule

>>> rtl/core/adam_parameter_update.sv
// Adam optimizer weight update, fixed point, one result beat per input beat.
// Input stream s_axis: tdata = layer_index, element_index, weight_in, gradient
// (low bits first), tlast = last_in_layer. Output stream m_axis: tdata =
// weight_out, tuser = saturated, tlast = last_out. Config channel cfg_*:
// index 0 beta_one, 1 beta_two, 2 step_size, 3 step_number.
// After reset the moment stores are swept to zero, one entry per cycle, over
// all LAYERS*ELEMENTS entries; s_axis_tready stays low meanwhile.
// Writing a beta or the step number recomputes both bias terms;
// cfg_ready is low during the recomputation and queued beats wait for it.
// The time a beat spends in the execution unit is set by the shared
// bit-serial divider (up to three passes of 64, 64 and 40 steps; the second
// and third are skipped on saturation) and the 32-step square root.
// A four-entry queue lets the input side keep taking beats while the unit
// works; a stalled m_axis_tready holds the result register and the unit.
module adam_parameter_update import adp_pkg::*; #(
  parameter int LAYERS   = 8,
  parameter int ELEMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // layer_index[2:0], element_index[12:3],
                                      // weight_in[44:13], gradient[76:45]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // weight_out[31:0]
  output logic        m_axis_tuser,   // saturated[0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = LAYERS * ELEMENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  adp_cfg_t      regs;
  logic          head_valid, pop, clearing;
  adp_item_t     head_item;
  logic [AW-1:0] head_addr;

  adp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  adp_front #(.LAYERS(LAYERS), .ELEMENTS(ELEMENTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .head_addr     (head_addr),
    .pop           (pop)
  );

  adp_exec #(.LAYERS(LAYERS), .ELEMENTS(ELEMENTS)) u_exec (
    .clk           (clk),
    .rst           (rst),
    .regs          (regs),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .head_addr     (head_addr),
    .pop           (pop),
    .clearing      (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> test/tb_adam_parameter_update.sv
module tb_adam_parameter_update import adp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_LAYERS   = 8;
  localparam int  NUM_ELEMENTS = 1024;
  localparam int  CYCLE_LIMIT  = 2_000_000;
  localparam int  DRAIN_CYCLES = 250;

  typedef struct {
    logic [2:0]         layer;
    logic [9:0]         elem;
    logic signed [31:0] weight;
    logic signed [31:0] grad;
    logic               last;
  } grad_beat_t;

  typedef struct {
    logic [31:0] weight;
    logic        sat;
    logic        last;
  } weight_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  adam_parameter_update dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // expected moments and registers
  logic signed [31:0] first_mom [NUM_LAYERS*NUM_ELEMENTS];
  logic [63:0]        second_mom [NUM_LAYERS*NUM_ELEMENTS];
  logic [31:0]        beta1 = BETA_ONE_RST;
  logic [31:0]        beta2 = BETA_TWO_RST;
  logic [31:0]        lrate = LR_RST;
  logic [20:0]        step_t = STEP_RST;
  logic [31:0]        bias1 = BIAS_ONE_RST;
  logic [31:0]        bias2 = BIAS_TWO_RST;

  grad_beat_t   pending_beats[$];
  weight_beat_t expected_weights[$];
  grad_beat_t   on_bus;
  int           errors = 0;
  int           cycles = 0;
  int           send_idle = 0;
  int           recv_idle = 0;

  initial begin
    for (int i = 0; i < NUM_LAYERS * NUM_ELEMENTS; i++) begin
      first_mom[i]  = '0;
      second_mom[i] = '0;
    end
  end

  function automatic logic [31:0] bias_power(logic [31:0] beta, logic [20:0] t);
    logic [63:0] acc;
    logic [63:0] base;
    logic [64:0] diff;
    acc  = 64'h1_0000_0000;
    base = {32'b0, beta};
    for (int i = 0; i < 21; i++) begin
      if (t[i]) acc = (acc * base) >> 32;
      base = (base * base) >> 32;
    end
    diff = 65'h1_0000_0000 - {1'b0, acc};
    if (diff > 65'hFFFF_FFFF) return 32'hFFFF_FFFF;
    if (diff == 0) return 32'd1;
    return diff[31:0];
  endfunction

  function automatic logic [31:0] root_floor(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (32'd1 << i);
      if (64'(c) * 64'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [31:0] d);
    case (idx)
      REG_BETA_ONE:    beta1 = d;
      REG_BETA_TWO:    beta2 = d;
      REG_STEP_SIZE:   lrate = d;
      REG_STEP_NUMBER: step_t = d[20:0];
      default: ;
    endcase
    bias1 = bias_power(beta1, step_t);
    bias2 = bias_power(beta2, step_t);
  endfunction

  function automatic weight_beat_t predict_update(grad_beat_t it);
    int            addr;
    longint        b1;
    longint        mo;
    longint        gg;
    longint        acc;
    longint        m1;
    longint        res;
    logic [63:0]   gmag;
    logic [63:0]   g2;
    logic [127:0]  p1;
    logic [127:0]  p2;
    logic [63:0]   v2;
    logic          neg;
    logic [63:0]   mmag;
    logic [63:0]   mhat;
    logic [127:0]  vq;
    logic [63:0]   vhat;
    logic [31:0]   s;
    logic [127:0]  q;
    logic [63:0]   upd;
    weight_beat_t  r;
    addr = {it.layer, it.elem};
    b1   = longint'({32'b0, beta1});
    mo   = longint'(first_mom[addr]);
    gg   = longint'(it.grad);
    acc  = b1 * mo + (64'sh1_0000_0000 - b1) * gg;
    m1   = acc >>> 32;
    first_mom[addr] = m1[31:0];

    gmag = (gg < 0) ? -gg : gg;
    g2   = gmag * gmag;
    p1   = 128'(second_mom[addr]) * 128'(beta2);
    p2   = 128'(g2) * 128'(33'h1_0000_0000 - {1'b0, beta2});
    v2   = p1[95:32] + p2[95:32];
    second_mom[addr] = v2;

    neg  = m1 < 0;
    mmag = neg ? -m1 : m1;
    mhat = (mmag << 32) / {32'b0, bias1};

    vq   = (128'(v2) << 32) / 128'(bias2);
    vhat = (vq > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : vq[63:0];
    vhat = (vhat > ~64'd0 - EPS_Q32) ? '1 : vhat + EPS_Q32;
    s    = root_floor(vhat);

    q   = (128'(lrate) * 128'(mhat)) / (128'(s) << 16);
    upd = (q >= 128'(UPDATE_CAP)) ? 64'(UPDATE_CAP) : q[63:0];

    res = neg ? longint'(it.weight) + longint'(upd) : longint'(it.weight) - longint'(upd);
    r.sat = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.weight = res[31:0];
    r.last   = it.last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_weights.push_back(predict_update(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          on_bus = pending_beats.pop_front();
          s_axis_tdata  <= {3'b0, on_bus.grad, on_bus.weight, on_bus.elem, on_bus.layer};
          s_axis_tlast  <= on_bus.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    weight_beat_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_weights.size() == 0) begin
          $display("%0t: unexpected result beat weight=%h sat=%b last=%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          want = expected_weights.pop_front();
          if (m_axis_tdata !== want.weight) begin
            $display("%0t: weight_out expected %h actual %h", $time, want.weight, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, m_axis_tuser);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_weights.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || expected_weights.size() != 0 || s_axis_tvalid);
  endtask

  task automatic push_beat(int layer, int elem, logic [31:0] w, logic [31:0] g, bit last);
    grad_beat_t b;
    b.layer  = layer[2:0];
    b.elem   = elem[9:0];
    b.weight = w;
    b.grad   = g;
    b.last   = last;
    pending_beats.push_back(b);
  endtask

  task automatic push_random(int count);
    int          layer;
    int          elem;
    logic [31:0] w;
    logic [31:0] g;
    int          sel;
    for (int i = 0; i < count; i++) begin
      layer = $urandom_range(NUM_LAYERS - 1);
      // keep most traffic on a few elements so the moments build up
      elem  = ($urandom_range(99) < 85) ? (($urandom_range(1)) ? $urandom_range(3)
                                                               : 1020 + $urandom_range(3))
                                        : $urandom_range(NUM_ELEMENTS - 1);
      sel = $urandom_range(99);
      if (sel < 40)      g = $urandom_range(32'h4_0000) - 32'h2_0000;
      else if (sel < 70) g = $urandom;
      else if (sel < 80) g = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else               g = ($urandom_range(32'h100_0000)) * ($urandom_range(1) ? 1 : -1);
      sel = $urandom_range(99);
      if (sel < 15)      w = 32'h7FFF_FFFF - $urandom_range(32'hFFFF);
      else if (sel < 30) w = 32'h8000_0000 + $urandom_range(32'hFFFF);
      else               w = $urandom;
      push_beat(layer, elem, w, g, $urandom_range(1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      send_idle = (p < 3) ? 23 : (p < 6) ? 72 : 0;
      recv_idle = (p < 3) ? 72 : (p < 6) ? 23 : 0;
      case (p)
        0: begin
          push_beat(0, 0, 32'h0, 32'h0, 1'b0);
          push_beat(7, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
          push_beat(7, 1023, 32'h8000_0000, 32'h8000_0000, 1'b0);
          push_beat(7, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
          push_beat(3, 5, 32'h0001_0000, 32'h0000_0001, 1'b0);
          push_beat(3, 5, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
          for (int i = 0; i < 6; i++) push_beat(1, 2, 32'h0002_0000, 32'h0001_0000, i == 5);
          for (int i = 0; i < 4; i++) push_beat(1, 2, 32'hFFFE_0000, 32'hFFFF_0000, 1'b0);
          push_beat(2, 9, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
          push_beat(2, 10, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
          push_beat(4, 512, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
          push_beat(5, 341, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
          push_beat(6, 682, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        end
        1: push_random(200);
        2: begin
          cfg_write(REG_BETA_ONE, 32'h0);
          cfg_write(REG_BETA_TWO, 32'h0);
          cfg_write(REG_STEP_SIZE, 32'hFFFF_FFFF);
          cfg_write(REG_STEP_NUMBER, 32'd1);
          push_random(120);
        end
        3: begin
          cfg_write(REG_BETA_ONE, 32'hFFFF_FFFF);
          cfg_write(REG_BETA_TWO, 32'hFFFF_FFFF);
          cfg_write(REG_STEP_SIZE, 32'h0);
          cfg_write(REG_STEP_NUMBER, 32'hFFE0_0000);
          push_random(120);
        end
        4: begin
          cfg_write(REG_BETA_ONE, $urandom);
          cfg_write(REG_BETA_TWO, $urandom);
          cfg_write(REG_STEP_SIZE, $urandom);
          cfg_write(REG_STEP_NUMBER, 32'd1048576);
          push_random(150);
        end
        5: begin
          cfg_write(REG_STEP_NUMBER, $urandom | 32'hFFE0_0000);
          cfg_write(REG_STEP_SIZE, $urandom);
          push_random(150);
        end
        6: begin
          cfg_write(REG_BETA_ONE, BETA_ONE_RST);
          cfg_write(REG_BETA_TWO, BETA_TWO_RST);
          cfg_write(REG_STEP_NUMBER, $urandom_range(1, 20));
          cfg_write(REG_STEP_SIZE, 32'hF000_0000);
          push_random(200);
        end
        default: begin
          cfg_write(REG_BETA_ONE, $urandom);
          cfg_write(REG_BETA_TWO, 32'hFFFF_0000 | $urandom_range(32'hFFFF));
          cfg_write(REG_STEP_SIZE, $urandom_range(32'h0100_0000));
          cfg_write(REG_STEP_NUMBER, $urandom_range(1, 1048576));
          push_random(235);
        end
      endcase
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> adam_parameter_update.f
rtl/core/adp_pkg.sv
rtl/core/adp_cfg.sv
rtl/core/adp_front.sv
rtl/core/adp_exec.sv
rtl/core/adam_parameter_update.sv
test/tb_adam_parameter_update.sv
